// File: rtl/mnsr_pkg.sv
// ----------------------------------------------------------------------------
// mnsr_pkg
// shared types and codes for the midi note state reconciler
// ----------------------------------------------------------------------------
package mnsr_pkg;

   // command codes
   localparam logic [1:0] CMD_PLAY    = 2'd0;
   localparam logic [1:0] CMD_RECORD  = 2'd1;
   localparam logic [1:0] CMD_SYNC    = 2'd2;
   localparam logic [1:0] CMD_RELEASE = 2'd3;

   // event kinds on the request side
   localparam logic [1:0] EV_PROG = 2'd0;
   localparam logic [1:0] EV_OFF  = 2'd1;
   localparam logic [1:0] EV_ON   = 2'd2;

   // event kinds on the response side
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_PROG = 2'd1;
   localparam logic [1:0] KIND_OFF  = 2'd2;
   localparam logic [1:0] KIND_ON   = 2'd3;

   localparam int MAX_RESULTS = 3;

   typedef struct packed {
      logic [1:0] cmd;
      logic [1:0] event_kind;
      logic [3:0] channel;
      logic [6:0] note;
      logic [6:0] value;
   } req_word_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] out_channel;
      logic [6:0] out_note;
      logic [6:0] out_value;
      logic       last;
      logic       scan_done;
   } rsp_word_type;

   // decoded operation passed from front to back
   typedef enum logic [2:0] {
      OP_PLAY_PROG = 3'd0,
      OP_PLAY_NOTE = 3'd1,
      OP_REC_PROG  = 3'd2,
      OP_REC_NOTE  = 3'd3,
      OP_SYNC      = 3'd4,
      OP_RELEASE   = 3'd5
   } op_kind_type;

   typedef struct packed {
      op_kind_type op;
      logic [1:0]  kind;
      logic [3:0]  channel;
      logic [6:0]  note;
      logic [6:0]  value;
      logic [7:0]  entry;
   } op_type;

   // up to three response words written in the same cycle
   typedef struct packed {
      logic [1:0]                       count;
      rsp_word_type [MAX_RESULTS-1:0]   word;
   } rsp_push_type;

endpackage

// File: rtl/mnsr_ram.sv
// ----------------------------------------------------------------------------
// mnsr_ram
// generic one write port, one read port ram with registered read data
// ----------------------------------------------------------------------------
module mnsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mnsr_front.sv
// ----------------------------------------------------------------------------
// mnsr_front
// accepts request words, drops ignored ones, decodes the rest into a
// two entry operation queue
// ----------------------------------------------------------------------------
module mnsr_front import mnsr_pkg::*; #(
   parameter int CHANNELS = 16,
   parameter int NOTES    = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_word_type req_word,
   input  logic         hold,
   output logic         op_valid,
   output op_type       op,
   input  logic         op_pop
);

   op_type     entries_ff [2];
   logic       head_ff;
   logic       head_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       ch_ok;
   logic       note_ok;
   logic       keep;
   logic       enq;
   logic       deq;
   op_type     dec;

   assign ch_ok   = {1'b0, req_word.channel} < 5'(CHANNELS);
   assign note_ok = {1'b0, req_word.note} < 8'(NOTES);

   always_comb begin
      dec         = '0;
      dec.channel = req_word.channel;
      dec.note    = req_word.note;
      dec.value   = req_word.value;
      dec.entry   = (req_word.event_kind == EV_ON) ? {1'b1, req_word.value} : 8'd0;
      dec.kind    = (req_word.event_kind == EV_ON) ? KIND_ON : KIND_OFF;
      dec.op      = OP_SYNC;
      keep        = 1'b0;
      unique case (req_word.cmd)
         CMD_PLAY, CMD_RECORD: begin
            if (req_word.event_kind == EV_PROG) begin
               keep    = ch_ok;
               dec.op  = (req_word.cmd == CMD_PLAY) ? OP_PLAY_PROG : OP_REC_PROG;
               dec.kind = KIND_PROG;
            end else if (req_word.event_kind == EV_OFF || req_word.event_kind == EV_ON) begin
               keep   = ch_ok && note_ok;
               dec.op = (req_word.cmd == CMD_PLAY) ? OP_PLAY_NOTE : OP_REC_NOTE;
            end
         end
         CMD_SYNC: begin
            keep   = 1'b1;
            dec.op = OP_SYNC;
         end
         CMD_RELEASE: begin
            keep   = ch_ok && note_ok;
            dec.op = OP_RELEASE;
         end
         default: keep = 1'b0;
      endcase
   end

   assign full     = hold || (count_ff == 2'd2);
   assign enq      = push && !full && keep;
   assign op_valid = (count_ff != 2'd0);
   assign deq      = op_pop && op_valid;
   assign op       = entries_ff[head_ff];
   assign head_in  = head_ff ^ deq;
   assign count_in = count_ff + 2'(enq) - 2'(deq);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      if (enq) begin
         entries_ff[head_ff ^ count_ff[0]] <= dec;
      end
   end

endmodule

// File: rtl/mnsr_rsp_queue.sv
// ----------------------------------------------------------------------------
// mnsr_rsp_queue
// four entry response queue, takes up to three words a cycle
// ----------------------------------------------------------------------------
module mnsr_rsp_queue import mnsr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rsp_push_type push_words,
   output logic         room,
   output logic         empty,
   input  logic         pop,
   output rsp_word_type rsp_word
);

   rsp_word_type words_ff [4];
   logic [1:0]   head_ff;
   logic [2:0]   count_ff;
   logic         deq;

   assign empty    = (count_ff == 3'd0);
   assign room     = (count_ff <= 3'd1);
   assign deq      = pop && !empty;
   assign rsp_word = words_ff[head_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         head_ff  <= head_ff + 2'(deq);
         count_ff <= count_ff + 3'(push_words.count) - 3'(deq);
      end
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (2'(k) < push_words.count) begin
            words_ff[2'(head_ff + count_ff[1:0] + 2'(k))] <= push_words.word[k];
         end
      end
   end

endmodule

// File: rtl/mnsr_back.sv
// ----------------------------------------------------------------------------
// mnsr_back
// executes decoded operations against the live and shadow tables and
// produces the response words
// ----------------------------------------------------------------------------
module mnsr_back import mnsr_pkg::*; #(
   parameter int CHANNELS = 16,
   parameter int NOTES    = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         op_valid,
   input  op_type       op,
   output logic         op_pop,
   input  logic         room,
   output rsp_push_type push_words,
   output logic         clearing
);

   localparam int SLOTS  = CHANNELS * NOTES;
   localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int NOTE_W = (NOTES > 1) ? $clog2(NOTES) : 1;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0] scan_addr_ff, scan_addr_in;
   logic [CH_W-1:0]   scan_ch_ff, scan_ch_in;
   logic [NOTE_W-1:0] scan_note_ff, scan_note_in;
   logic              latch_ff, latch_in;
   op_type            cur_ff, cur_in;
   logic [ADDR_W-1:0] cur_addr_ff, cur_addr_in;
   logic [6:0]        live_prog_ff [CHANNELS];
   logic [6:0]        live_prog_in [CHANNELS];
   logic [6:0]        shadow_prog_ff [CHANNELS];
   logic [6:0]        shadow_prog_in [CHANNELS];

   logic [ADDR_W-1:0] op_addr;
   logic [CH_W-1:0]   op_ch;

   logic              live_wr_en, shadow_wr_en;
   logic [ADDR_W-1:0] live_wr_addr, shadow_wr_addr;
   logic [7:0]        live_wr_data, shadow_wr_data;
   logic              live_rd_en, shadow_rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        live_rd_data, shadow_rd_data;

   // sync step result
   rsp_push_type      sync_words;
   logic [1:0]        sync_n;
   logic              note0;
   logic              prog_diff;
   logic              sync_latch;
   logic              scan_last;
   logic              old_on, new_on;

   assign op_addr  = ADDR_W'(op.channel) * ADDR_W'(NOTES) + ADDR_W'(op.note);
   assign op_ch    = op.channel[CH_W-1:0];
   assign clearing = (state_ff == ST_CLEAR);

   mnsr_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_live_ram (
      .clock   (clock),
      .wr_en   (live_wr_en),
      .wr_addr (live_wr_addr),
      .wr_data (live_wr_data),
      .rd_en   (live_rd_en),
      .rd_addr (rd_addr),
      .rd_data (live_rd_data)
   );

   mnsr_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_shadow_ram (
      .clock   (clock),
      .wr_en   (shadow_wr_en),
      .wr_addr (shadow_wr_addr),
      .wr_data (shadow_wr_data),
      .rd_en   (shadow_rd_en),
      .rd_addr (rd_addr),
      .rd_data (shadow_rd_data)
   );

   // sync step: program change first, then note events
   always_comb begin
      sync_words = '0;
      sync_n     = 2'd0;
      note0      = (scan_note_ff == '0);
      prog_diff  = (live_prog_ff[scan_ch_ff] != shadow_prog_ff[scan_ch_ff]);
      sync_latch = note0 ? prog_diff : latch_ff;
      scan_last  = (scan_addr_ff == ADDR_W'(SLOTS - 1));
      old_on     = live_rd_data[7];
      new_on     = shadow_rd_data[7];
      if (note0 && prog_diff) begin
         sync_words.word[sync_n].kind        = KIND_PROG;
         sync_words.word[sync_n].out_channel = 4'(scan_ch_ff);
         sync_words.word[sync_n].out_value   = shadow_prog_ff[scan_ch_ff];
         sync_n = sync_n + 2'd1;
      end
      if (old_on && new_on
          && ((live_rd_data[6:0] != shadow_rd_data[6:0]) || sync_latch)) begin
         sync_words.word[sync_n].kind        = KIND_OFF;
         sync_words.word[sync_n].out_channel = 4'(scan_ch_ff);
         sync_words.word[sync_n].out_note    = 7'(scan_note_ff);
         sync_n = sync_n + 2'd1;
         sync_words.word[sync_n].kind        = KIND_ON;
         sync_words.word[sync_n].out_channel = 4'(scan_ch_ff);
         sync_words.word[sync_n].out_note    = 7'(scan_note_ff);
         sync_words.word[sync_n].out_value   = shadow_rd_data[6:0];
         sync_n = sync_n + 2'd1;
      end else if (old_on && !new_on) begin
         sync_words.word[sync_n].kind        = KIND_OFF;
         sync_words.word[sync_n].out_channel = 4'(scan_ch_ff);
         sync_words.word[sync_n].out_note    = 7'(scan_note_ff);
         sync_n = sync_n + 2'd1;
      end else if (!old_on && new_on) begin
         sync_words.word[sync_n].kind        = KIND_ON;
         sync_words.word[sync_n].out_channel = 4'(scan_ch_ff);
         sync_words.word[sync_n].out_note    = 7'(scan_note_ff);
         sync_words.word[sync_n].out_value   = shadow_rd_data[6:0];
         sync_n = sync_n + 2'd1;
      end
      // empty step still reports scan progress
      if (sync_n == 2'd0) begin
         sync_n = 2'd1;
      end
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (2'(k) < sync_n) begin
            sync_words.word[k].scan_done = scan_last;
         end
      end
      sync_words.word[sync_n - 2'd1].last = 1'b1;
      sync_words.count = sync_n;
   end

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      scan_addr_in   = scan_addr_ff;
      scan_ch_in     = scan_ch_ff;
      scan_note_in   = scan_note_ff;
      latch_in       = latch_ff;
      cur_in         = cur_ff;
      cur_addr_in    = cur_addr_ff;
      live_prog_in   = live_prog_ff;
      shadow_prog_in = shadow_prog_ff;
      op_pop         = 1'b0;
      push_words     = '0;
      live_wr_en     = 1'b0;
      live_wr_addr   = op_addr;
      live_wr_data   = op.entry;
      shadow_wr_en   = 1'b0;
      shadow_wr_addr = op_addr;
      shadow_wr_data = op.entry;
      live_rd_en     = 1'b0;
      shadow_rd_en   = 1'b0;
      rd_addr        = op_addr;

      unique case (state_ff)
         ST_CLEAR: begin
            live_wr_en     = 1'b1;
            shadow_wr_en   = 1'b1;
            live_wr_addr   = clr_addr_ff;
            shadow_wr_addr = clr_addr_ff;
            live_wr_data   = 8'd0;
            shadow_wr_data = 8'd0;
            clr_addr_in    = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (op_valid && room) begin
               op_pop      = 1'b1;
               cur_in      = op;
               cur_addr_in = op_addr;
               unique case (op.op)
                  OP_PLAY_PROG: begin
                     live_prog_in[op_ch]               = op.value;
                     push_words.count                  = 2'd1;
                     push_words.word[0].kind           = KIND_PROG;
                     push_words.word[0].out_channel    = op.channel;
                     push_words.word[0].out_value      = op.value;
                     push_words.word[0].last           = 1'b1;
                  end
                  OP_PLAY_NOTE: begin
                     live_wr_en                        = 1'b1;
                     push_words.count                  = 2'd1;
                     push_words.word[0].kind           = op.kind;
                     push_words.word[0].out_channel    = op.channel;
                     push_words.word[0].out_note       = op.note;
                     push_words.word[0].out_value      = op.value;
                     push_words.word[0].last           = 1'b1;
                  end
                  OP_REC_PROG: begin
                     shadow_prog_in[op_ch] = op.value;
                  end
                  OP_REC_NOTE: begin
                     shadow_wr_en = 1'b1;
                  end
                  OP_RELEASE: begin
                     live_rd_en = 1'b1;
                     state_in   = ST_EXEC;
                  end
                  OP_SYNC: begin
                     live_rd_en   = 1'b1;
                     shadow_rd_en = 1'b1;
                     rd_addr      = scan_addr_ff;
                     state_in     = ST_EXEC;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (cur_ff.op)
               OP_RELEASE: begin
                  live_wr_addr = cur_addr_ff;
                  live_wr_data = 8'd0;
                  if (live_rd_data[7]) begin
                     live_wr_en                     = 1'b1;
                     push_words.count               = 2'd1;
                     push_words.word[0].kind        = KIND_OFF;
                     push_words.word[0].out_channel = cur_ff.channel;
                     push_words.word[0].out_note    = cur_ff.note;
                     push_words.word[0].last        = 1'b1;
                  end
               end
               OP_SYNC: begin
                  push_words     = sync_words;
                  latch_in       = sync_latch;
                  live_wr_en     = 1'b1;
                  live_wr_addr   = scan_addr_ff;
                  live_wr_data   = shadow_rd_data;
                  shadow_wr_en   = 1'b1;
                  shadow_wr_addr = scan_addr_ff;
                  shadow_wr_data = 8'd0;
                  if (note0 && prog_diff) begin
                     live_prog_in[scan_ch_ff] = shadow_prog_ff[scan_ch_ff];
                  end
                  if (scan_last) begin
                     scan_addr_in = '0;
                     scan_ch_in   = '0;
                     scan_note_in = '0;
                  end else begin
                     scan_addr_in = scan_addr_ff + ADDR_W'(1);
                     if (scan_note_ff == NOTE_W'(NOTES - 1)) begin
                        scan_note_in = '0;
                        scan_ch_in   = scan_ch_ff + CH_W'(1);
                     end else begin
                        scan_note_in = scan_note_ff + NOTE_W'(1);
                     end
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         scan_addr_ff <= '0;
         scan_ch_ff   <= '0;
         scan_note_ff <= '0;
         latch_ff     <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            live_prog_ff[c]   <= 7'd0;
            shadow_prog_ff[c] <= 7'd0;
         end
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         scan_addr_ff   <= scan_addr_in;
         scan_ch_ff     <= scan_ch_in;
         scan_note_ff   <= scan_note_in;
         latch_ff       <= latch_in;
         live_prog_ff   <= live_prog_in;
         shadow_prog_ff <= shadow_prog_in;
      end
      cur_ff      <= cur_in;
      cur_addr_ff <= cur_addr_in;
   end

endmodule

// File: rtl/midi_note_state_reconciler_top.sv
// a play word passes the operation queue, then the response queue; release and
//   sync also pass the execution state; each operation waits for response room
// play and record finish in the idle state; release and sync read the table
//   ram there, then compare and write back in the execution state
// reset: full stays high while both note tables are swept to zero, one entry
//   per cycle; programs and the scan clear at once
// ----------------------------------------------------------------------------
// midi_note_state_reconciler_top
// live and shadow midi note tables with play, record, sync and release
// ----------------------------------------------------------------------------
module midi_note_state_reconciler_top import mnsr_pkg::*; #(
   parameter int CHANNELS = 16,
   parameter int NOTES    = 128
) (
   input  logic         clock,
   input  logic         reset,
   // request queue side
   input  logic         push,
   output logic         full,
   input  req_word_type req_word,
   // response queue side
   output logic         empty,
   input  logic         pop,
   output rsp_word_type rsp_word
);

   // decoded operation between front and back
   logic         op_valid;
   op_type       op;
   logic         op_pop;
   // back to response queue
   rsp_push_type push_words;
   logic         room;
   // table sweep in progress after reset
   logic         clearing;

   // front: takes each word while full is low, drops ignored words, queues the rest
   mnsr_front #(.CHANNELS(CHANNELS), .NOTES(NOTES)) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_word (req_word),
      .hold     (clearing),
      .op_valid (op_valid),
      .op       (op),
      .op_pop   (op_pop)
   );

   // back: owns the tables and the scan position, only starts an operation
   // when the response queue can take its worst case of three words
   mnsr_back #(.CHANNELS(CHANNELS), .NOTES(NOTES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (op_valid),
      .op         (op),
      .op_pop     (op_pop),
      .room       (room),
      .push_words (push_words),
      .clearing   (clearing)
   );

   // response queue: parts the back from a stalled consumer
   mnsr_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_words (push_words),
      .room       (room),
      .empty      (empty),
      .pop        (pop),
      .rsp_word   (rsp_word)
   );

endmodule

// File: rtl/mnsr_checker.sv
// ----------------------------------------------------------------------------
// mnsr_checker
// port level checks for the midi note state reconciler
// ----------------------------------------------------------------------------
module mnsr_checker import mnsr_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         push,
   input logic         full,
   input req_word_type req_word,
   input logic         empty,
   input logic         pop,
   input rsp_word_type rsp_word
);

   // a waiting word holds until it is taken
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_word)))
      else $error("response word changed while stalled");

   // table sweep holds off requests right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (full && empty))
      else $error("block not held after reset");

   // a filler word only ends an empty sync step
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_word.kind == KIND_NONE) |->
         (rsp_word.last && rsp_word.out_channel == 4'd0))
      else $error("bad filler word");

   // program changes carry no note
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_word.kind == KIND_PROG) |-> (rsp_word.out_note == 7'd0))
      else $error("program change with a note");

endmodule

bind midi_note_state_reconciler_top mnsr_checker u_checker (.*);
